[rtl/core/lbs_pkg.sv]
//------------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants for the skinning engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package lbs_pkg;

  localparam int JOINTS     = 64;
  localparam int JW         = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int PDEPTH     = JOINTS * 12;
  localparam int NDEPTH     = JOINTS * 9;
  localparam int PAW        = $clog2(PDEPTH);
  localparam int NAW        = $clog2(NDEPTH);
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_LOAD_POS  = 2'd0,
    OP_LOAD_NORM = 2'd1,
    OP_INFLUENCE = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         joint;
    logic [3:0]         element;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        weight;
    logic               last_influence;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_norm_x;
    logic signed [31:0] out_norm_y;
    logic signed [31:0] out_norm_z;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic               use_joint;  // joint in range: contributes
    logic               last;
    logic [JW-1:0]      joint;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0]        weight;     // clamped to one
  } job_t;

  // matrix write from front to tables
  typedef struct packed {
    logic               pos_we;
    logic [PAW-1:0]     pos_addr;
    logic               norm_we;
    logic [NAW-1:0]     norm_addr;
    logic signed [31:0] data;
  } mwr_t;

endpackage

[rtl/core/lbs_ram.sv]
//------------------------------------------------------------------------------
// lbs_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/lbs_front.sv]
//------------------------------------------------------------------------------
// lbs_front
// Accepts requests, writes matrix loads, queues influence jobs.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lbs_front import lbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output mwr_t     mwr,
  output logic     job_valid,
  input  logic     job_pop,
  output job_t     job
);
  job_t          q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           acc, is_inf, in_rng, push;
  job_t           nj;

  // non-influence requests wait until every queued influence has finished
  assign in_ready = (cnt_r != (QAW+1)'(QDEPTH)) && (is_inf || (cnt_r == '0));
  assign acc      = in_valid && in_ready;
  assign in_rng   = {26'd0, in_data.joint} < 32'(JOINTS);
  assign is_inf   = (in_data.operation == OP_INFLUENCE);
  assign push     = acc && is_inf;

  always_comb begin
    mwr.pos_we    = acc && (in_data.operation == OP_LOAD_POS) && in_rng &&
                    (in_data.element < 4'd12);
    mwr.norm_we   = acc && (in_data.operation == OP_LOAD_NORM) && in_rng &&
                    (in_data.element < 4'd9);
    mwr.pos_addr  = PAW'(in_data.joint[JW-1:0] * 12 + in_data.element);
    mwr.norm_addr = NAW'(in_data.joint[JW-1:0] * 9 + in_data.element);
    mwr.data      = in_data.matrix_value;
    nj.use_joint  = in_rng;
    nj.last       = in_data.last_influence;
    nj.joint      = in_data.joint[JW-1:0];
    nj.px         = in_data.pos_x;
    nj.py         = in_data.pos_y;
    nj.pz         = in_data.pos_z;
    nj.nx         = in_data.norm_x;
    nj.ny         = in_data.norm_y;
    nj.nz         = in_data.norm_z;
    nj.weight     = (in_data.weight > 16'd32768) ? 16'd32768 : in_data.weight;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (job_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(job_pop);
    end
    if (push) q_r[wp_r] <= nj;
  end

  assign job_valid = (cnt_r != '0);
  assign job       = q_r[rp_r];
endmodule

[rtl/core/lbs_back.sv]
//------------------------------------------------------------------------------
// lbs_back
// Sequencer: one shared 32x32 multiplier, fetches matrix elements, accumulates.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lbs_back import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mwr_t      mwr,
  input  logic      job_valid,
  output logic      job_pop,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WMUL, S_EMIT} st_t;

  st_t               st_r;
  logic [1:0]        r_r;       // row
  logic [1:0]        c_r;       // column within row
  logic              nrm_r;     // normal phase
  logic              rv_r;      // read data valid
  logic [1:0]        rc_r;      // column of read data
  logic              rn_r;
  logic signed [63:0] prod_r;
  logic              pv_r;
  logic [1:0]        pc_r;
  logic              pn_r;
  logic signed [49:0] t_r;
  logic signed [49:0] trow_r;   // finished row sum
  logic              tv_r;
  logic signed [47:0] acc_r [6];
  logic [2:0]        ai_r;
  logic              wdo_r;
  logic signed [31:0] pm_q, nm_q;
  logic [PAW-1:0]    praddr;
  logic [NAW-1:0]    nraddr;
  out_item_t         od_r;
  logic              ov_r;

  lbs_ram #(.WIDTH(32), .DEPTH(PDEPTH)) u_pm (
    .clk, .we(mwr.pos_we), .waddr(mwr.pos_addr), .wdata(mwr.data),
    .raddr(praddr), .rdata(pm_q));
  lbs_ram #(.WIDTH(32), .DEPTH(NDEPTH)) u_nm (
    .clk, .we(mwr.norm_we), .waddr(mwr.norm_addr), .wdata(mwr.data),
    .raddr(nraddr), .rdata(nm_q));

  assign praddr = PAW'(job.joint * 12 + r_r * 4 + c_r);
  assign nraddr = NAW'(job.joint * 9 + r_r * 3 + c_r);

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    if (x > 50'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (x < -50'sh800000000000) return 48'sh800000000000;
    return x[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (x < -48'sh80000000) return 32'sh80000000;
    return x[31:0];
  endfunction

  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [49:0] addend;
  logic signed [49:0] tw_in;
  logic signed [66:0] tw;
  logic               cols_done, last_rd;

  // mul operand selection
  always_comb begin
    ma = rn_r ? nm_q : pm_q;
    unique case (rc_r)
      2'd0:    mb = rn_r ? 32'(job.nx) : job.px;
      2'd1:    mb = rn_r ? 32'(job.ny) : job.py;
      default: mb = rn_r ? 32'(job.nz) : job.pz;
    endcase
    // translation column: prod_r holds the sign-extended element
    if (pc_r == 2'd3) addend = 50'(prod_r);
    else if (pn_r)    addend = 50'(prod_r >>> 15);
    else              addend = 50'(prod_r >>> 16);
    cols_done = pn_r ? (pc_r == 2'd2) : (pc_r == 2'd3);
    tw_in     = t_r + addend;
    tw        = trow_r * $signed({1'b0, job.weight});
    last_rd   = nrm_r && (r_r == 2'd2) && (c_r == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      rv_r  <= 1'b0;
      pv_r  <= 1'b0;
      tv_r  <= 1'b0;
      ov_r  <= 1'b0;
      wdo_r <= 1'b0;
      for (int i = 0; i < 6; i++) acc_r[i] <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      rv_r  <= (st_r == S_RUN);
      pv_r  <= rv_r;
      tv_r  <= pv_r && cols_done;
      wdo_r <= tv_r && (ai_r == 3'd5);
      // stage 1: multiply (translation passes straight through)
      if (rv_r) begin
        prod_r <= (rc_r == 2'd3) ? 64'(ma) : ma * mb;
        pc_r   <= rc_r;
        pn_r   <= rn_r;
      end
      // stage 2: row sum
      if (pv_r) begin
        if (cols_done) begin
          trow_r <= tw_in;
          t_r    <= '0;
        end else begin
          t_r <= tw_in;
        end
      end
      // stage 3: weight and accumulate
      if (tv_r) begin
        acc_r[ai_r] <= sat48(50'(acc_r[ai_r]) + 50'(tw >>> 15));
        ai_r <= ai_r + 3'd1;
      end
      unique case (st_r)
        S_IDLE: begin
          r_r   <= '0;
          c_r   <= '0;
          nrm_r <= 1'b0;
          t_r   <= '0;
          ai_r  <= '0;
          if (job_valid && !ov_r) begin
            st_r <= job.use_joint ? S_RUN : S_EMIT;
          end
        end
        S_RUN: begin
          rc_r <= c_r;
          rn_r <= nrm_r;
          if (last_rd) begin
            st_r <= S_WMUL;
          end else if (!nrm_r && c_r == 2'd3) begin
            c_r <= '0;
            if (r_r == 2'd2) begin
              r_r <= '0; nrm_r <= 1'b1;
            end else r_r <= r_r + 2'd1;
          end else if (nrm_r && c_r == 2'd2) begin
            c_r <= '0; r_r <= r_r + 2'd1;
          end else c_r <= c_r + 2'd1;
        end
        S_WMUL: begin
          if (wdo_r) st_r <= S_EMIT;
        end
        default: begin
          st_r <= S_IDLE;
          if (job.last) begin
            ov_r <= 1'b1;
            od_r.out_pos_x  <= sat32(acc_r[0]);
            od_r.out_pos_y  <= sat32(acc_r[1]);
            od_r.out_pos_z  <= sat32(acc_r[2]);
            od_r.out_norm_x <= sat32(acc_r[3]);
            od_r.out_norm_y <= sat32(acc_r[4]);
            od_r.out_norm_z <= sat32(acc_r[5]);
            for (int i = 0; i < 6; i++) acc_r[i] <= '0;
          end
        end
      endcase
    end
  end

  assign job_pop   = (st_r == S_EMIT);
  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

[rtl/core/linear_blend_skinning.sv]
//------------------------------------------------------------------------------
// linear_blend_skinning
// Top level of the linear blend skinning engine.
//------------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_ready as in_item_t. Operation 0 and 1
// load one position or normal matrix element for a joint; they are written
// straight into the matrix RAMs in the accept cycle and give no result.
// Loads (and unused operations) are held off until every queued influence
// has finished, so an influence always sees the matrices loaded before it.
// Operation 2 is a vertex influence; it is queued (four deep) for the back
// end, which walks 21 matrix reads through one shared 32x32 multiplier and
// adds the weighted rows into six saturating 48-bit accumulators.
// An influence flagged last produces one out_item_t request on
// out_valid/out_ready, carrying the saturated blended position and normal;
// the accumulators are then cleared.
// Each influence passes a start state, the matrix reads, a drain of multiply,
// row sum and accumulate, and a retire state; the back end takes no new
// influence until the last has retired, and loads never enter the queue.
// A stalled receiver holds the output register; the back end then waits
// before the next influence while the front queue keeps filling.
// Reset (rst_n low, synchronous) clears the queue, sequencer and the
// accumulators; matrix RAMs are undefined until written.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module linear_blend_skinning import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  mwr_t mwr;
  logic job_valid, job_pop;
  job_t job;

  lbs_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .mwr, .job_valid, .job_pop, .job);

  lbs_back u_back (
    .clk, .rst_n, .mwr, .job_valid, .job_pop, .job,
    .out_valid, .out_ready, .out_data);
endmodule

[rtl/core/lbs_checker.sv]
//------------------------------------------------------------------------------
// lbs_checker
// Port-level checks for the skinning engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lbs_checker import lbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && in_data.operation != OP_INFLUENCE
    |=> !out_valid)
    else $error("result out of a load");

  a_ready_rst: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");
endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);
